// File: sv/running_median_two_heaps_core_defines.svh
// Assertion macros for the running median core
`ifndef RUNNING_MEDIAN_TWO_HEAPS_CORE_DEFINES_SVH
`define RUNNING_MEDIAN_TWO_HEAPS_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define RMH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("running median check failed");

// Consequent checked in the cycle after the antecedent
`define RMH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("running median check failed");

`endif

// File: sv/rmh_pkg.sv
// Shared types and constants of the running median core
package rmh_pkg;

  localparam int unsigned HeapDepth     = 512;
  localparam int unsigned SampleBits    = 32;
  localparam int unsigned InSampleWidth = 32;
  localparam int unsigned MedianWidth   = 33;
  localparam int unsigned CountWidth    = 11;

  // Sequencer states, one-hot
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StXfer = 4'b0010,
    StIns  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  // Command broadcast to every cell of one chain
  typedef struct packed {
    logic push;
    logic pop;
  } chain_cmd_t;

endpackage

// File: sv/rmh_if.sv
// Handshake channels of the running median core
interface rmh_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [rmh_pkg::InSampleWidth-1:0]   sample;
  logic                                       first_of_stream;

  modport source (output valid, output sample, output first_of_stream, input ready);
  modport sink   (input valid, input sample, input first_of_stream, output ready);
endinterface

interface rmh_out_if;
  logic                                     valid;
  logic                                     ready;
  logic signed [rmh_pkg::MedianWidth-1:0]   median_x2;
  logic        [rmh_pkg::CountWidth-1:0]    sample_count;
  logic                                     overflow;

  modport source (output valid, output median_x2, output sample_count, output overflow,
                  input ready);
  modport sink   (input valid, input median_x2, input sample_count, input overflow,
                  output ready);
endinterface

// File: sv/rmh_cell.sv
// One slot of a sorted heap chain: holds a value, shifts on push or pop
module rmh_cell #(
  parameter int unsigned W     = rmh_pkg::SampleBits,
  parameter bit          IsMax = 1'b1,
  parameter bit          First = 1'b0
) (
  input  logic                clk_i,
  input  rmh_pkg::chain_cmd_t cmd_i,
  input  logic signed [W-1:0] new_i,
  input  logic signed [W-1:0] prev_i,
  input  logic signed [W-1:0] next_i,
  input  logic                prev_valid_i,
  input  logic                self_valid_i,
  output logic signed [W-1:0] val_o
);

  logic signed [W-1:0] val_q, val_d;
  logic                new_beats_self, new_beats_prev;
  logic                lands_here_or_before, lands_before;

  // Ordering compare, strict so equal values queue behind
  assign new_beats_self = IsMax ? (new_i > val_q) : (new_i < val_q);
  assign new_beats_prev = IsMax ? (new_i > prev_i) : (new_i < prev_i);

  assign lands_here_or_before = !self_valid_i || new_beats_self;
  assign lands_before = !First && (!prev_valid_i || new_beats_prev);

  // Next slot value
  always_comb begin
    val_d = val_q;
    if (cmd_i.pop) begin
      val_d = next_i;
    end else if (cmd_i.push && lands_here_or_before) begin
      val_d = lands_before ? prev_i : new_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

// File: sv/rmh_chain.sv
// Row of cells keeping one heap as a sorted list, top in cell zero
module rmh_chain #(
  parameter int unsigned Depth = rmh_pkg::HeapDepth,
  parameter int unsigned W     = rmh_pkg::SampleBits,
  parameter bit          IsMax = 1'b1,
  localparam int unsigned CW   = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  rmh_pkg::chain_cmd_t cmd_i,
  input  logic signed [W-1:0] new_i,
  input  logic [CW-1:0]       count_i,
  output logic signed [W-1:0] top_o
);

  logic signed [W-1:0] vals [Depth];
  logic                valid [Depth];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // Slot holds a live entry when it lies below the fill count
    assign valid[i] = CW'(i) < count_i;

    rmh_cell #(
      .W     (W),
      .IsMax (IsMax),
      .First (i == 0)
    ) u_cell (
      .clk_i        (clk_i),
      .cmd_i        (cmd_i),
      .new_i        (new_i),
      .prev_i       (vals[(i == 0) ? 0 : i - 1]),
      .next_i       (vals[(i == Depth - 1) ? i : i + 1]),
      .prev_valid_i (valid[(i == 0) ? 0 : i - 1]),
      .self_valid_i (valid[i]),
      .val_o        (vals[i])
    );
  end

  assign top_o = vals[0];

endmodule

// File: sv/running_median_two_heaps_core.sv
// Running median core: a sequencer over two sorted chains of cells.
// Each accepted item goes through StXfer when a top moves between heaps, then StIns
// and StEmit, where the result is registered, or straight to StEmit on overflow;
// StEmit waits while the output stalls. The sequencer runs one item at a time.
// Reset clears both fill counts and the previous median; heap cells are not reset.
`include "running_median_two_heaps_core_defines.svh"

module running_median_two_heaps_core #(
  parameter int unsigned HEAP_DEPTH  = rmh_pkg::HeapDepth,
  parameter int unsigned SAMPLE_BITS = rmh_pkg::SampleBits
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rmh_in_if.sink        in_i,
  rmh_out_if.source     out_o
);

  localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned SB = SAMPLE_BITS;

  rmh_pkg::state_e state_q, state_d;

  logic [CW-1:0]         lcnt_q, lcnt_d, ucnt_q, ucnt_d;
  logic signed [SB:0]    last_q, last_d;
  logic signed [SB-1:0]  s_q;
  logic                  below_q, xfer_q, ovf_q;

  logic signed [SB-1:0]  s_in, ltop, utop, push_val;
  logic [CW-1:0]         lc, uc, gc;
  logic signed [SB:0]    last_in, med;
  logic                  below, grow_lower, accept;
  rmh_pkg::chain_cmd_t   lcmd, ucmd;

  logic                              out_valid_q;
  logic signed [rmh_pkg::MedianWidth-1:0] out_med_q;
  logic [rmh_pkg::CountWidth-1:0]    out_cnt_q;
  logic                              out_ovf_q;
  logic                              out_load;

  // Input decode and placement decision
  assign s_in     = SB'(in_i.sample);
  assign accept   = in_i.valid && in_i.ready;
  assign lc       = in_i.first_of_stream ? '0 : lcnt_q;
  assign uc       = in_i.first_of_stream ? '0 : ucnt_q;
  assign last_in  = in_i.first_of_stream ? '0 : last_q;
  assign below    = $signed({s_in, 1'b0}) < last_in;
  assign grow_lower = (lc > uc) ? 1'b0 : ((lc < uc) ? 1'b1 : below);
  assign gc       = grow_lower ? lc : uc;

  assign in_i.ready = (state_q == rmh_pkg::StIdle);

  // Median from the chain tops
  always_comb begin
    if (lcnt_q == ucnt_q) begin
      med = {ltop[SB-1], ltop} + {utop[SB-1], utop};
    end else if (lcnt_q > ucnt_q) begin
      med = {ltop, 1'b0};
    end else begin
      med = {utop, 1'b0};
    end
  end

  assign out_load = (state_q == rmh_pkg::StEmit) && (!out_valid_q || out_o.ready);

  // Chain commands
  always_comb begin
    lcmd     = '0;
    ucmd     = '0;
    push_val = s_q;
    unique case (state_q)
      rmh_pkg::StXfer: begin
        if (below_q) begin
          lcmd.pop  = 1'b1;
          ucmd.push = 1'b1;
          push_val  = ltop;
        end else begin
          ucmd.pop  = 1'b1;
          lcmd.push = 1'b1;
          push_val  = utop;
        end
      end
      rmh_pkg::StIns: begin
        lcmd.push = below_q;
        ucmd.push = !below_q;
      end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    lcnt_d  = lcnt_q;
    ucnt_d  = ucnt_q;
    last_d  = last_q;
    unique case (state_q)
      rmh_pkg::StIdle: begin
        if (accept) begin
          lcnt_d = lc;
          ucnt_d = uc;
          last_d = last_in;
          if (gc >= CW'(HEAP_DEPTH)) begin
            state_d = rmh_pkg::StEmit;
          end else if ((lc > uc && below) || (lc < uc && !below)) begin
            state_d = rmh_pkg::StXfer;
          end else begin
            state_d = rmh_pkg::StIns;
          end
        end
      end
      rmh_pkg::StXfer: begin
        if (below_q) begin
          lcnt_d = lcnt_q - 1'b1;
          ucnt_d = ucnt_q + 1'b1;
        end else begin
          ucnt_d = ucnt_q - 1'b1;
          lcnt_d = lcnt_q + 1'b1;
        end
        state_d = rmh_pkg::StIns;
      end
      rmh_pkg::StIns: begin
        if (below_q) begin
          lcnt_d = lcnt_q + 1'b1;
        end else begin
          ucnt_d = ucnt_q + 1'b1;
        end
        state_d = rmh_pkg::StEmit;
      end
      rmh_pkg::StEmit: begin
        if (out_load) begin
          last_d  = ovf_q ? last_q : med;
          state_d = rmh_pkg::StIdle;
        end
      end
      default: state_d = rmh_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rmh_pkg::StIdle;
      lcnt_q      <= '0;
      ucnt_q      <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      lcnt_q  <= lcnt_d;
      ucnt_q  <= ucnt_d;
      last_q  <= last_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item payload and plan
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s_q     <= s_in;
      below_q <= below;
      xfer_q  <= (lc > uc && below) || (lc < uc && !below);
      ovf_q   <= gc >= CW'(HEAP_DEPTH);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_med_q <= rmh_pkg::MedianWidth'(ovf_q ? last_q : med);
      out_cnt_q <= rmh_pkg::CountWidth'({1'b0, lcnt_q} + {1'b0, ucnt_q});
      out_ovf_q <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.median_x2    = out_med_q;
  assign out_o.sample_count = out_cnt_q;
  assign out_o.overflow     = out_ovf_q;

  rmh_chain #(
    .Depth (HEAP_DEPTH),
    .W     (SB),
    .IsMax (1'b1)
  ) u_lower (
    .clk_i   (clk_i),
    .cmd_i   (lcmd),
    .new_i   (push_val),
    .count_i (lcnt_q),
    .top_o   (ltop)
  );

  rmh_chain #(
    .Depth (HEAP_DEPTH),
    .W     (SB),
    .IsMax (1'b0)
  ) u_upper (
    .clk_i   (clk_i),
    .cmd_i   (ucmd),
    .new_i   (push_val),
    .count_i (ucnt_q),
    .top_o   (utop)
  );

  // Checks
  `RMH_ASSERT_NOW(a_balanced, state_q == rmh_pkg::StIdle,
                  ({1'b0, lcnt_q} <= {1'b0, ucnt_q} + 1'b1) &&
                  ({1'b0, ucnt_q} <= {1'b0, lcnt_q} + 1'b1))
  `RMH_ASSERT_NOW(a_bounded, 1'b1,
                  (lcnt_q <= CW'(HEAP_DEPTH)) && (ucnt_q <= CW'(HEAP_DEPTH)))
  `RMH_ASSERT_NEXT(a_xfer_path, state_q == rmh_pkg::StXfer, state_q == rmh_pkg::StIns)
  `RMH_ASSERT_NEXT(a_plan, accept && !(gc >= CW'(HEAP_DEPTH)),
                   (state_q == rmh_pkg::StXfer) == xfer_q)

endmodule

// File: test/running_median_two_heaps_core_test.sv
// Testbench of the running median core: directed table, a fill to overflow, then random streams checked by a model
module running_median_two_heaps_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned RandomItems = 60;

  typedef struct packed {
    logic signed [rmh_pkg::MedianWidth-1:0] median_x2;
    logic [rmh_pkg::CountWidth-1:0]         sample_count;
    logic                                   overflow;
  } median_res_t;

  typedef struct {
    logic signed [rmh_pkg::InSampleWidth-1:0] sample;
    logic                                     first;
    logic                                     has_exp;
    median_res_t                              exp;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  rmh_in_if  in_ch();
  rmh_out_if out_ch();

  running_median_two_heaps_core u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #1 clk_i = ~clk_i;

  // Model state: both halves as sorted queues (lower ascending, upper ascending)
  longint lower_half[$];
  longint upper_half[$];
  longint prev_med_x2;
  median_res_t pending_medians[$];
  stim_row_t   directed_rows[$];
  int unsigned fail_count = 0;
  int unsigned idle_cycles = 0;
  bit          rx_stall = 1'b0;

  // Insert keeping ascending order
  function automatic void sorted_insert(ref longint q[$], input longint v);
    int k;
    k = 0;
    while (k < q.size() && q[k] < v) k++;
    q.insert(k, v);
  endfunction

  function automatic median_res_t predict_median(logic signed [31:0] smp, logic first);
    longint s;
    bit below;
    bit grow_lower;
    int unsigned grow_n;
    longint top;
    median_res_t r;
    s = smp;
    if (first) begin
      lower_half.delete();
      upper_half.delete();
      prev_med_x2 = 0;
    end
    below = (s * 2) < prev_med_x2;
    if (lower_half.size() > upper_half.size()) grow_lower = 1'b0;
    else if (lower_half.size() < upper_half.size()) grow_lower = 1'b1;
    else grow_lower = below;
    grow_n = grow_lower ? lower_half.size() : upper_half.size();
    r.overflow = 1'b0;
    if (grow_n >= rmh_pkg::HeapDepth) begin
      r.overflow = 1'b1;
    end else if (lower_half.size() > upper_half.size()) begin
      if (below) begin
        top = lower_half.pop_back();
        sorted_insert(upper_half, top);
        sorted_insert(lower_half, s);
      end else begin
        sorted_insert(upper_half, s);
      end
      prev_med_x2 = lower_half[$] + upper_half[0];
    end else if (lower_half.size() == upper_half.size()) begin
      if (below) begin
        sorted_insert(lower_half, s);
        prev_med_x2 = lower_half[$] * 2;
      end else begin
        sorted_insert(upper_half, s);
        prev_med_x2 = upper_half[0] * 2;
      end
    end else begin
      if (below) begin
        sorted_insert(lower_half, s);
      end else begin
        top = upper_half.pop_front();
        sorted_insert(lower_half, top);
        sorted_insert(upper_half, s);
      end
      prev_med_x2 = lower_half[$] + upper_half[0];
    end
    r.median_x2 = prev_med_x2[rmh_pkg::MedianWidth-1:0];
    r.sample_count = rmh_pkg::CountWidth'(lower_half.size() + upper_half.size());
    return r;
  endfunction

  function automatic void add_row(logic signed [31:0] s, logic f, logic he,
                                  longint m, int c, logic o);
    stim_row_t row;
    row.sample = s;
    row.first = f;
    row.has_exp = he;
    row.exp.median_x2 = m[rmh_pkg::MedianWidth-1:0];
    row.exp.sample_count = rmh_pkg::CountWidth'(c);
    row.exp.overflow = o;
    directed_rows.push_back(row);
  endfunction

  // Offer one item, honoring the bursty sender, and wait for acceptance
  task automatic send_sample(logic signed [31:0] s, logic f, logic he, median_res_t ex);
    median_res_t p;
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.first_of_stream <= f;
    do @(posedge clk_i); while (!in_ch.ready);
    p = predict_median(s, f);
    if (he && p != ex) begin
      $error("table row disagrees with model: exp %0d/%0d/%0d model %0d/%0d/%0d",
             ex.median_x2, ex.sample_count, ex.overflow,
             p.median_x2, p.sample_count, p.overflow);
      fail_count++;
    end
    pending_medians.push_back(he ? ex : p);
  endtask

  task automatic sender_gap();
    if ($urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= $urandom();
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // Random value: full range, extremes, or small values to get ties and near-median picks
  function automatic logic signed [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      1, 2: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom();
    endcase
  endfunction

  // Receiver stall pattern and checking
  always @(posedge clk_i or negedge rst_ni) begin
    median_res_t ex;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_medians.size() == 0) begin
          $error("result with no item pending");
          fail_count++;
        end else begin
          ex = pending_medians.pop_front();
          if (out_ch.median_x2 !== ex.median_x2) begin
            $error("median_x2 exp %0d got %0d", ex.median_x2, out_ch.median_x2);
            fail_count++;
          end
          if (out_ch.sample_count !== ex.sample_count) begin
            $error("sample_count exp %0d got %0d", ex.sample_count, out_ch.sample_count);
            fail_count++;
          end
          if (out_ch.overflow !== ex.overflow) begin
            $error("overflow exp %0d got %0d", ex.overflow, out_ch.overflow);
            fail_count++;
          end
        end
      end
      out_ch.ready <= rx_stall ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  // Switch between stretches of steady and stalling receiver
  always @(posedge clk_i) if ($urandom_range(0, 63) == 0) rx_stall <= ~rx_stall;

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    median_res_t none;
    int n;
    int run_len;
    none = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.first_of_stream = 1'b0;
    prev_med_x2 = 0;

    // Directed: first samples, extremes, ties, reopening the stream
    add_row(32'sd0, 1'b0, 1'b1, 0, 1, 1'b0);
    add_row(32'sd10, 1'b0, 1'b1, 10, 2, 1'b0);
    add_row(-32'sd4, 1'b0, 1'b1, 0, 3, 1'b0);
    add_row(32'sd5, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(32'sd5, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(-32'sd1, 1'b1, 1'b1, -2, 1, 1'b0);
    add_row(32'sh7fffffff, 1'b1, 1'b1, 64'sh0fffffffe, 1, 1'b0);
    add_row(32'sh7fffffff, 1'b0, 1'b1, 64'sh0fffffffe, 2, 1'b0);
    add_row(32'sh80000000, 1'b1, 1'b1, -64'sh100000000, 1, 1'b0);
    add_row(32'sh80000000, 1'b0, 1'b1, -64'sh100000000, 2, 1'b0);
    add_row(32'sh7fffffff, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(32'sh7fffffff, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(32'sh55555555, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(32'shaaaaaaaa, 1'b0, 1'b0, 0, 0, 1'b0);
    add_row(32'sd0, 1'b1, 1'b1, 0, 1, 1'b0);
    add_row(32'sd0, 1'b0, 1'b1, 0, 2, 1'b0);
    add_row(32'sd3, 1'b0, 1'b0, 0, 0, 1'b0);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_sample(directed_rows[i].sample, directed_rows[i].first,
                  directed_rows[i].has_exp, directed_rows[i].exp);
      sender_gap();
    end

    // Fill to overflow once, both above-median and below-median paths
    send_sample(32'sd0, 1'b1, 1'b0, none);
    for (int k = 0; k < 1030; k++) begin
      send_sample(32'($signed($urandom_range(0, 200)) - 100), 1'b0, 1'b0, none);
      if ($urandom_range(0, 15) == 0) sender_gap();
    end

    // Random streams of mostly short length
    n = 0;
    while (n < RandomItems) begin
      run_len = $urandom_range(0, 7) == 0 ? $urandom_range(40, 120) : $urandom_range(1, 15);
      for (int k = 0; k < run_len && n < RandomItems; k++) begin
        send_sample(rand_sample(), k == 0 ? 1'b1 : ($urandom_range(0, 50) == 0), 1'b0, none);
        sender_gap();
        n++;
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_medians.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/rmh_pkg.sv
sv/rmh_if.sv
sv/rmh_cell.sv
sv/rmh_chain.sv
sv/running_median_two_heaps_core.sv
test/running_median_two_heaps_core_test.sv
